// ----- design/cqf_pkg.sv -----
// ----------------------------------------------------------------------------
// cqf_pkg: shared types and constants for the circular queue FIFO
// Action and status codes, the result word and the controller states.
// ----------------------------------------------------------------------------
package cqf_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;

  // action codes on the item channel; code 3 is unused and ignored
  localparam logic [1:0] ACT_ENQ     = 2'd0;
  localparam logic [1:0] ACT_DEQ     = 2'd1;
  localparam logic [1:0] ACT_DISPLAY = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   data;
    logic                       last;
  } res_t;

endpackage

// ----- design/cqf_ram.sv -----
// ----------------------------------------------------------------------------
// cqf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module cqf_ram #(
  parameter int WIDTH = cqf_pkg::DATA_W,
  parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/cqf_obuf.sv -----
// ----------------------------------------------------------------------------
// cqf_obuf: two-entry output buffer
// Decouples result delivery from the controller; exposes its fill count.
// ----------------------------------------------------------------------------
module cqf_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cqf_pkg::res_t  push_word,
  output logic [1:0]     count,
  output logic           result_valid,
  input  logic           result_stall,
  output cqf_pkg::res_t  head_word
);

  cqf_pkg::res_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic          pop;

  assign result_valid = (count != 2'd0);
  assign pop          = result_valid && !result_stall;
  assign head_word    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- design/circular_queue_fifo.sv -----
// ----------------------------------------------------------------------------
// circular_queue_fifo: circular FIFO of signed 32-bit words
// Enqueue / dequeue / display over a RAM-backed ring with head and tail.
// ----------------------------------------------------------------------------
// The queue words live in a DEPTH-entry RAM with a registered read;
// head, tail and occupancy are flops. Items are taken one at a time. An
// enqueue writes the tail slot and its status word is queued in the same
// cycle; a dequeue reads the head slot and its word comes out of the RAM in
// the next cycle. A display walks the ring from head, one RAM read per stored
// element, and emits one word per element with last set on the final one.
// Overflow, underflow, empty display and the unused action code need no RAM
// read. A display holds the item side while it accepts the item, issues its
// reads and waits for the last word to land. A read is only issued when the
// output buffer has room for it and for the word still in flight, so even
// with the result side taking every word at once the walk must wait between
// some reads; result stalls stretch it further.
// A two-entry output buffer sits between the controller and the result port,
// so the next item can be taken while a result still waits.
// ----------------------------------------------------------------------------
module circular_queue_fifo #(
  parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        action,
  input  logic signed [cqf_pkg::DATA_W-1:0] value,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [1:0]                        status,
  output logic signed [cqf_pkg::DATA_W-1:0] data,
  output logic                              last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // ring pointers and fill level
  logic [AW-1:0]    head, head_next;
  logic [AW-1:0]    tail, tail_next;
  logic [CW-1:0]    occ, occ_next;

  // display walk
  cqf_pkg::state_t  state, state_next;
  logic [AW-1:0]    walk_pos, walk_pos_next;
  logic [CW-1:0]    walk_left, walk_left_next;

  // a RAM read is in flight; its word lands next cycle
  logic             rd_pending, rd_pending_next;
  logic             rd_last, rd_last_next;

  // RAM side
  logic                       ram_we;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [cqf_pkg::DATA_W-1:0] ram_rdata;

  // output buffer side
  logic                       push;
  cqf_pkg::res_t              push_word;
  cqf_pkg::res_t              out_word;
  logic [1:0]                 ob_count;

  logic                       accept;
  logic                       room;
  logic                       q_empty;
  logic                       q_full;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_empty = (occ == '0);
  assign q_full  = (occ == CW'(DEPTH));

  // room for one more word, counting the one still coming out of the RAM
  assign room = (ob_count + {1'b0, rd_pending}) < 2'd2;

  // take an item only when idle, no read in flight and output room (interlock:
  // the RAM is never read and written by two different items in the same cycle)
  assign item_stall = !((state == cqf_pkg::S_IDLE) && !rd_pending && room);
  assign accept     = item_valid && !item_stall;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      cqf_pkg::S_IDLE: begin
        if (accept && (action == cqf_pkg::ACT_DISPLAY) && !q_empty) begin
          state_next = cqf_pkg::S_WALK;
        end
      end
      cqf_pkg::S_WALK: begin
        if (room && (walk_left == CW'(1))) begin
          state_next = cqf_pkg::S_IDLE;
        end
      end
      default: state_next = cqf_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs and datapath ----------------
  always_comb begin
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = walk_pos;
    push            = 1'b0;
    push_word       = '{status: cqf_pkg::STAT_OK, data: '0, last: 1'b1};
    head_next       = head;
    tail_next       = tail;
    occ_next        = occ;
    walk_pos_next   = walk_pos;
    walk_left_next  = walk_left;
    rd_pending_next = 1'b0;
    rd_last_next    = rd_last;

    // word returning from the RAM
    if (rd_pending) begin
      push      = 1'b1;
      push_word = '{status: cqf_pkg::STAT_OK, data: ram_rdata, last: rd_last};
    end

    unique case (state)
      cqf_pkg::S_IDLE: begin
        if (accept) begin
          unique case (action)
            cqf_pkg::ACT_ENQ: begin
              push = 1'b1;
              if (q_full) begin
                push_word.status = cqf_pkg::STAT_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                tail_next = wrap_inc(tail);
                occ_next  = occ + 1'b1;
              end
            end
            cqf_pkg::ACT_DEQ: begin
              if (q_empty) begin
                push             = 1'b1;
                push_word.status = cqf_pkg::STAT_UNDERFLOW;
              end else begin
                ram_re          = 1'b1;
                ram_raddr       = head;
                head_next       = wrap_inc(head);
                occ_next        = occ - 1'b1;
                rd_pending_next = 1'b1;
                rd_last_next    = 1'b1;
              end
            end
            cqf_pkg::ACT_DISPLAY: begin
              if (q_empty) begin
                push             = 1'b1;
                push_word.status = cqf_pkg::STAT_EMPTY;
              end else begin
                walk_pos_next  = head;
                walk_left_next = occ;
              end
            end
            default: ;  // unused code: no result, no change
          endcase
        end
      end
      cqf_pkg::S_WALK: begin
        if (room) begin
          ram_re          = 1'b1;
          ram_raddr       = walk_pos;
          walk_pos_next   = wrap_inc(walk_pos);
          walk_left_next  = walk_left - 1'b1;
          rd_pending_next = 1'b1;
          rd_last_next    = (walk_left == CW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cqf_pkg::S_IDLE;
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      occ        <= occ_next;
      rd_pending <= rd_pending_next;
    end
  end

  // walk position, count and last flag are only meaningful when in use
  always_ff @(posedge clk) begin
    walk_pos  <= walk_pos_next;
    walk_left <= walk_left_next;
    rd_last   <= rd_last_next;
  end

  cqf_ram #(
    .WIDTH (cqf_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cqf_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_word    (push_word),
    .count        (ob_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head_word    (out_word)
  );

  assign status = out_word.status;
  assign data   = out_word.data;
  assign last   = out_word.last;

endmodule

// ----- design/circular_queue_fifo_chk.sv -----
// ----------------------------------------------------------------------------
// circular_queue_fifo_chk: port-level checks for the circular queue FIFO
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module circular_queue_fifo_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [1:0]                        status,
  input logic signed [cqf_pkg::DATA_W-1:0] data,
  input logic                              last
);

  // a stalled result word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(status) && $stable(data) && $stable(last))
    else $error("result word changed while stalled");

  // error and empty reports are single words with zero data
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != cqf_pkg::STAT_OK) |-> last && (data == '0))
    else $error("error status without last or with nonzero data");

  // reset empties the output buffer
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind circular_queue_fifo circular_queue_fifo_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .data         (data),
  .last         (last)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for circular_queue_fifo
// A directed table (reset, extremes, overflow, underflow, empty display,
// unused action, wrap) and then random traffic with biased fill/drain phases.
// Every accepted word on the result side is checked against a local queue
// model or a directed row; both sides idle at random, the result side holds off once long.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH       = cqf_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS  = 360;
  localparam int PRESSURE_AT = 60;      // items taken before the long hold-off
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 500000;

  // action code with no meaning; the block ignores it
  localparam logic [1:0] ACT_NONE = 2'd3;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // queue model decides
    CHK_NONE,   // no word may come back
    CHK_WORD    // the single word typed in the row
  } row_check_t;

  typedef struct packed {
    logic [1:0]         act;
    logic signed [31:0] val;
    row_check_t         chk;
    cqf_pkg::status_t   st;
    logic signed [31:0] dat;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  logic [1:0]          action;
  logic signed [31:0]  value;
  logic                result_valid;
  logic                result_stall;
  logic [1:0]          status;
  logic signed [31:0]  data;
  logic                last;

  circular_queue_fifo #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .data         (data),
    .last         (last)
  );

  // queue model state
  logic signed [31:0] model_ring [DEPTH];
  int                 model_head;
  int                 model_tail;
  int                 model_count;

  cqf_pkg::res_t pending_words [$];  // words still owed by the block, oldest first
  step_row_t     directed_rows [$];
  int            errors;
  int            items_taken;
  int            cycles;

  // all inputs known from time zero
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    action       = cqf_pkg::ACT_ENQ;
    value        = '0;
    result_stall = 1'b0;
    errors       = 0;
    items_taken  = 0;
    cycles       = 0;
    model_head   = 0;
    model_tail   = 0;
    model_count  = 0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit; also drives the calm windows below
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("circular_queue_fifo regression: fail");
      $finish;
    end
  end

  // idle length for either side: mostly none or short, now and then long.
  // Inside a calm window nobody idles, so back-to-back traffic is seen too.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if ((cycles % 1200) >= 1000) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic owe_word(input cqf_pkg::status_t st, input logic signed [31:0] d,
                          input logic l);
    cqf_pkg::res_t w;
    w.status = st;
    w.data   = d;
    w.last   = l;
    pending_words.push_back(w);
  endtask

  // one accepted item through the queue model; keep=0 only advances state
  task automatic queue_model_step(input logic [1:0] act, input logic signed [31:0] val,
                                  input bit keep);
    int k;
    case (act)
      cqf_pkg::ACT_ENQ: begin
        if (model_count >= DEPTH) begin
          if (keep) owe_word(cqf_pkg::STAT_OVERFLOW, 0, 1'b1);
        end else begin
          model_ring[model_tail] = val;
          model_tail  = (model_tail + 1) % DEPTH;
          model_count = model_count + 1;
          if (keep) owe_word(cqf_pkg::STAT_OK, 0, 1'b1);
        end
      end
      cqf_pkg::ACT_DEQ: begin
        if (model_count == 0) begin
          if (keep) owe_word(cqf_pkg::STAT_UNDERFLOW, 0, 1'b1);
        end else begin
          if (keep) owe_word(cqf_pkg::STAT_OK, model_ring[model_head], 1'b1);
          model_head  = (model_head + 1) % DEPTH;
          model_count = model_count - 1;
        end
      end
      cqf_pkg::ACT_DISPLAY: begin
        if (model_count == 0) begin
          if (keep) owe_word(cqf_pkg::STAT_EMPTY, 0, 1'b1);
        end else if (keep) begin
          // head to tail, last only on the newest word; queue untouched
          for (k = 0; k < model_count; k++)
            owe_word(cqf_pkg::STAT_OK, model_ring[(model_head + k) % DEPTH],
                     k == model_count - 1);
        end
      end
      default: ;  // unused code: no word, no state change
    endcase
  endtask

  // Offer one item: optional idle gap, then hold valid and payload until taken.
  // Called at a falling edge; returns at the rising edge that takes the item.
  task automatic offer_item(input logic [1:0] act, input logic signed [31:0] val);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    value      <= val;
    do @(posedge clk); while (item_stall !== 1'b0);
    items_taken = items_taken + 1;
  endtask

  task automatic row(input logic [1:0] a, input logic signed [31:0] v, input row_check_t c,
                     input cqf_pkg::status_t s, input logic signed [31:0] d);
    step_row_t r;
    r.act = a;
    r.val = v;
    r.chk = c;
    r.st  = s;
    r.dat = d;
    directed_rows.push_back(r);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- sender
  initial begin : item_side
    int         i;
    int         counted;
    int         fill_pct;
    int         r;
    logic [1:0] act;
    step_row_t  sr;

    // from reset: nothing stored
    row(cqf_pkg::ACT_DEQ,     32'sd0,         CHK_WORD,  cqf_pkg::STAT_UNDERFLOW, 0);
    row(cqf_pkg::ACT_DISPLAY, 32'sd0,         CHK_WORD,  cqf_pkg::STAT_EMPTY,     0);
    row(ACT_NONE,             32'sh5a5a_5a5a, CHK_NONE,  cqf_pkg::STAT_OK,        0);
    // extremes of value
    row(cqf_pkg::ACT_ENQ,     32'sh8000_0000, CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'sh7fff_ffff, CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'sd0,         CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     -32'sd1,        CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_DISPLAY, 32'sd0,         CHK_MODEL, cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_DEQ,     32'sd0,         CHK_WORD,  cqf_pkg::STAT_OK,
        32'sh8000_0000);
    // fill to the brim; tail wraps past slot zero; one more overflows
    row(cqf_pkg::ACT_ENQ,     32'sd5,         CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'sh0f0f_0f0f, CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'shf0f0_f0f0, CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'sh1234_5678, CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'shedcb_a987, CHK_WORD,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_ENQ,     32'sd99,        CHK_WORD,  cqf_pkg::STAT_OVERFLOW,  0);
    row(ACT_NONE,             32'sh7fff_ffff, CHK_NONE,  cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_DISPLAY, 32'sd0,         CHK_MODEL, cqf_pkg::STAT_OK,        0);
    // drain through the wrap, then one too many
    for (i = 0; i < DEPTH; i++)
      row(cqf_pkg::ACT_DEQ,   32'sd0,         CHK_MODEL, cqf_pkg::STAT_OK,        0);
    row(cqf_pkg::ACT_DEQ,     32'sd0,         CHK_WORD,  cqf_pkg::STAT_UNDERFLOW, 0);
    row(cqf_pkg::ACT_DISPLAY, 32'sd0,         CHK_WORD,  cqf_pkg::STAT_EMPTY,     0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      sr = directed_rows[n];
      offer_item(sr.act, sr.val);
      if (sr.chk == CHK_MODEL) begin
        queue_model_step(sr.act, sr.val, 1'b1);
      end else begin
        queue_model_step(sr.act, sr.val, 1'b0);
        if (sr.chk == CHK_WORD) owe_word(sr.st, sr.dat, 1'b1);
      end
      @(negedge clk);
    end

    // random part: fill/drain bias is redrawn every 25 items so the queue
    // swings between full and empty; unused codes do not count
    counted  = 0;
    fill_pct = 50;
    while (counted < RAND_ITEMS) begin
      if (counted % 25 == 0) begin
        r = $urandom_range(0, 2);
        fill_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
      end
      r = $urandom_range(0, 99);
      if (r < 5)       act = ACT_NONE;
      else if (r < 20) act = cqf_pkg::ACT_DISPLAY;
      else if ($urandom_range(0, 99) < fill_pct) act = cqf_pkg::ACT_ENQ;
      else             act = cqf_pkg::ACT_DEQ;
      offer_item(act, pick_value());
      queue_model_step(act, value, 1'b1);
      if (act != ACT_NONE) counted = counted + 1;
      @(negedge clk);
    end
    item_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("circular_queue_fifo regression: pass");
    else
      $display("circular_queue_fifo regression: fail");
    $finish;
  end

  // -------------------------------------------------------------- receiver
  // random stall runs, plus one long hold-off once traffic is flowing so the
  // output buffer fills and the block must stall its item side
  initial begin : result_side
    int run;
    bit held;
    held = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!held && items_taken >= PRESSURE_AT) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        run = idle_len();
        if (run > 0) begin
          result_stall <= 1'b1;
          repeat (run) @(negedge clk);
        end
        result_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------- checker
  always @(posedge clk) begin
    cqf_pkg::res_t w;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0d data %0d last %0d",
                 $time, status, data, last);
        errors = errors + 1;
      end else begin
        w = pending_words.pop_front();
        if (status !== w.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, w.status, status);
          errors = errors + 1;
        end
        if (data !== w.data) begin
          $display("%0t: data mismatch, expected %0d, got %0d", $time, w.data, data);
          errors = errors + 1;
        end
        if (last !== w.last) begin
          $display("%0t: last mismatch, expected %0d, got %0d", $time, w.last, last);
          errors = errors + 1;
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
design/cqf_pkg.sv
design/cqf_ram.sv
design/cqf_obuf.sv
design/circular_queue_fifo.sv
design/circular_queue_fifo_chk.sv
dv/tb.sv
